// ===== rtl/core/tpflr_pkg.sv =====
// Shared types, constants and control structures for the three-port RAM.
`default_nettype none

package tpflr_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned LAT_W         = 4;
  localparam int unsigned START_W       = 8;
  localparam int unsigned BASE_W        = 16;
  localparam int unsigned FADDR_W       = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned NUM_PORTS     = 3;
  localparam int unsigned NUM_BANKS     = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CFG_IDX_W     = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ACCESS_LATENCY = 2'd0;
  localparam cfg_idx_t CFG_STARTUP_TICKS  = 2'd1;
  localparam cfg_idx_t CFG_SECOND_BASE    = 2'd2;

  localparam logic [LAT_W-1:0]   LAT_RST   = 4'd9;
  localparam logic [START_W-1:0] START_RST = 8'd10;
  localparam logic [BASE_W-1:0]  BASE_RST  = 16'h0100;

  localparam logic FUNC_READ = 1'b1;

  typedef logic [1:0] port_idx_t;
  localparam port_idx_t PORT_DATA  = 2'd0;
  localparam port_idx_t PORT_INST1 = 2'd1;
  localparam port_idx_t PORT_INST2 = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PORT,
    ST_CAPTURE,
    ST_FINISH
  } tpflr_state_e;

  typedef struct packed {
    logic      clear;
    logic      accept;
    logic      mem_rd;
    logic      mem_wr;
    logic      capture;
    logic      load_out;
    port_idx_t port;
  } tpflr_cmd_t;

  typedef struct packed {
    logic                 clr_last;
    logic [NUM_PORTS-1:0] done;
    logic [NUM_PORTS-1:0] func;
    logic                 out_free;
  } tpflr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/three_port_fixed_latency_ram.sv =====
// Top level of the three-port RAM.
`default_nettype none

// A byte-addressed RAM of 2**ADDR_BITS bytes shared by one data port and two
// instruction ports. Each input request is one clock tick of the modeled
// system and carries all three port requests; each tick returns exactly one
// result with a done flag and read word per port. For the first startup_ticks
// ticks after reset (or after that register is written) the block only counts
// down. After that, every port with a request present counts its latency
// counter down and, when it expires, does a 32-bit little-endian read or write
// at any byte address, wrapping at the memory size; instruction port 2 adds
// second_port_base first. Within one tick the ports are served in the order
// data, instruction 1, instruction 2, so a later port sees an earlier write.
// After reset a clearing pass zeroes the memory, one row of four bytes per
// cycle; no request is accepted meanwhile, configuration writes are. A tick
// then passes the accepting idle state, a port state per port, a capture
// state per completing read (registered bank output) and a finishing state:
// the memory is four byte-wide single-port banks, served port by port. The
// finished result waits in an output register, so a stalled output does not
// block acceptance of the next request, whose result then waits until that
// register is free. Configuration writes are always ready and must only
// happen while the block is idle.

module three_port_fixed_latency_ram #(
  parameter int unsigned ADDR_BITS = tpflr_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             mem_valid_i,
  input  wire logic                             mem_func_i,
  input  wire logic [tpflr_pkg::FADDR_W-1:0]    mem_addr_i,
  input  wire logic [tpflr_pkg::DATA_W-1:0]     mem_wdata_i,
  input  wire logic                             inst1_valid_i,
  input  wire logic                             inst1_func_i,
  input  wire logic [tpflr_pkg::FADDR_W-1:0]    inst1_addr_i,
  input  wire logic [tpflr_pkg::DATA_W-1:0]     inst1_wdata_i,
  input  wire logic                             inst2_valid_i,
  input  wire logic                             inst2_func_i,
  input  wire logic [tpflr_pkg::FADDR_W-1:0]    inst2_addr_i,
  input  wire logic [tpflr_pkg::DATA_W-1:0]     inst2_wdata_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  mem_done_o,
  output logic      [tpflr_pkg::DATA_W-1:0]     mem_rdata_o,
  output logic                                  inst1_done_o,
  output logic      [tpflr_pkg::DATA_W-1:0]     inst1_rdata_o,
  output logic                                  inst2_done_o,
  output logic      [tpflr_pkg::DATA_W-1:0]     inst2_rdata_o,
  // configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire tpflr_pkg::cfg_idx_t              cfg_index_i,
  input  wire logic [tpflr_pkg::BASE_W-1:0]     cfg_wdata_i
);
  import tpflr_pkg::*;

  tpflr_cmd_t cmd;
  tpflr_sts_t sts;

  logic [NUM_PORTS-1:0] port_valid;
  logic [NUM_PORTS-1:0] port_func;
  logic [FADDR_W-1:0]   port_addr  [NUM_PORTS];
  logic [DATA_W-1:0]    port_wdata [NUM_PORTS];
  logic [NUM_PORTS-1:0] res_done;
  logic [DATA_W-1:0]    res_rdata  [NUM_PORTS];

  // Gather the three ports into arrays indexed by service order.
  assign port_valid = {inst2_valid_i, inst1_valid_i, mem_valid_i};
  assign port_func  = {inst2_func_i, inst1_func_i, mem_func_i};
  assign port_addr[PORT_DATA]   = mem_addr_i;
  assign port_addr[PORT_INST1]  = inst1_addr_i;
  assign port_addr[PORT_INST2]  = inst2_addr_i;
  assign port_wdata[PORT_DATA]  = mem_wdata_i;
  assign port_wdata[PORT_INST1] = inst1_wdata_i;
  assign port_wdata[PORT_INST2] = inst2_wdata_i;

  // Registers never back-pressure a write.
  assign cfg_ready_o = 1'b1;

  tpflr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpflr_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (port_valid),
    .func_i      (port_func),
    .addr_i      (port_addr),
    .wdata_i     (port_wdata),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_done_o  (res_done),
    .out_rdata_o (res_rdata)
  );

  // Spread the result back onto the per-port outputs.
  assign mem_done_o    = res_done[PORT_DATA];
  assign inst1_done_o  = res_done[PORT_INST1];
  assign inst2_done_o  = res_done[PORT_INST2];
  assign mem_rdata_o   = res_rdata[PORT_DATA];
  assign inst1_rdata_o = res_rdata[PORT_INST1];
  assign inst2_rdata_o = res_rdata[PORT_INST2];

endmodule

`default_nettype wire

// ===== rtl/core/tpflr_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module tpflr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tpflr_ctrl.sv =====
// Sequencer: clearing pass, tick acceptance, per-port memory accesses, result hand-off.
`default_nettype none

module tpflr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire tpflr_pkg::tpflr_sts_t sts_i,
  output tpflr_pkg::tpflr_cmd_t     cmd_o
);
  import tpflr_pkg::*;

  tpflr_state_e state_q, state_d;
  port_idx_t    idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= PORT_DATA;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.port = idx_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          idx_d        = PORT_DATA;
          state_d      = ST_PORT;
        end
      end
      ST_PORT: begin
        if (sts_i.done[idx_q] && (sts_i.func[idx_q] == FUNC_READ)) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_CAPTURE;
        end else begin
          cmd_o.mem_wr = sts_i.done[idx_q];
          if (idx_q == PORT_INST2) begin
            state_d = ST_FINISH;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      ST_CAPTURE: begin
        cmd_o.capture = 1'b1;
        if (idx_q == PORT_INST2) begin
          state_d = ST_FINISH;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_PORT;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tpflr_dp.sv =====
// Datapath: configuration, latency counters, tick registers, byte-lane banks, result register.
`default_nettype none

module tpflr_dp #(
  parameter int unsigned ADDR_BITS = tpflr_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tpflr_pkg::tpflr_cmd_t               cmd_i,
  output tpflr_pkg::tpflr_sts_t                    sts_o,
  input  wire logic                                cfg_we_i,
  input  wire tpflr_pkg::cfg_idx_t                 cfg_index_i,
  input  wire logic [tpflr_pkg::BASE_W-1:0]        cfg_wdata_i,
  input  wire logic [tpflr_pkg::NUM_PORTS-1:0]     valid_i,
  input  wire logic [tpflr_pkg::NUM_PORTS-1:0]     func_i,
  input  wire logic [tpflr_pkg::FADDR_W-1:0]       addr_i  [tpflr_pkg::NUM_PORTS],
  input  wire logic [tpflr_pkg::DATA_W-1:0]        wdata_i [tpflr_pkg::NUM_PORTS],
  input  wire logic                                out_stall_i,
  output logic                                     out_valid_o,
  output logic      [tpflr_pkg::NUM_PORTS-1:0]     out_done_o,
  output logic      [tpflr_pkg::DATA_W-1:0]        out_rdata_o [tpflr_pkg::NUM_PORTS]
);
  import tpflr_pkg::*;

  localparam int unsigned AW   = ADDR_BITS;
  localparam int unsigned RW   = ADDR_BITS - 2;
  localparam int unsigned ROWS = 1 << RW;
  localparam int unsigned WIDE = ADDR_BITS + FADDR_W + 1;

  // Configuration and tick-level state.
  logic [LAT_W-1:0]   lat_q;
  logic [BASE_W-1:0]  base_q;
  logic [START_W-1:0] start_q;
  logic [LAT_W-1:0]   wait_q [NUM_PORTS];
  logic [LAT_W-1:0]   wait_d [NUM_PORTS];
  logic [LAT_W-1:0]   wait_ld [NUM_PORTS];
  logic [NUM_PORTS-1:0] done_q, done_d;
  logic [RW-1:0]      clr_row_q;

  // Latched request of the current tick.
  logic [NUM_PORTS-1:0] func_q;
  logic [AW-1:0]      eaddr_q [NUM_PORTS];
  logic [AW-1:0]      eaddr   [NUM_PORTS];
  logic [WIDE-1:0]    wide_addr [NUM_PORTS];
  logic [DATA_W-1:0]  wdata_q [NUM_PORTS];
  logic [DATA_W-1:0]  rdata_q [NUM_PORTS];
  logic [FADDR_W:0]   sum2;

  // Output register.
  logic                 out_valid_q;
  logic [NUM_PORTS-1:0] out_done_q;
  logic [DATA_W-1:0]    out_rdata_q [NUM_PORTS];

  // Bank signals.
  logic [RW-1:0]          bank_addr  [NUM_BANKS];
  logic [BYTE_W-1:0]      bank_wdata [NUM_BANKS];
  logic [BYTE_W-1:0]      bank_q     [NUM_BANKS];
  logic [AW-1:0]          cur_addr;
  logic [1:0]             cur_off;
  logic [RW-1:0]          row0, row1;
  logic [NUM_BANKS-1:0][BYTE_W-1:0] wbytes;
  logic [NUM_BANKS-1:0][BYTE_W-1:0] rbytes;
  logic [1:0]             lane_sel [NUM_BANKS];
  logic [1:0]             byte_sel [NUM_BANKS];

  // Effective byte addresses, wrapped to the memory size.
  always_comb begin
    sum2                  = {1'b0, addr_i[PORT_INST2]} + {1'b0, base_q};
    wide_addr[PORT_DATA]  = WIDE'(addr_i[PORT_DATA]);
    wide_addr[PORT_INST1] = WIDE'(addr_i[PORT_INST1]);
    wide_addr[PORT_INST2] = WIDE'(sum2);
    for (int p = 0; p < NUM_PORTS; p++) begin
      eaddr[p] = wide_addr[p][AW-1:0];
    end
  end

  // Latency counters: advance only for ports with a request once startup is over.
  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      wait_ld[p] = (wait_q[p] == '0) ? lat_q : wait_q[p];
      wait_d[p]  = wait_q[p];
      done_d[p]  = 1'b0;
      if ((start_q == '0) && valid_i[p]) begin
        wait_d[p] = wait_ld[p] - 4'd1;
        done_d[p] = (wait_d[p] == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q     <= LAT_RST;
      base_q    <= BASE_RST;
      start_q   <= START_RST;
      done_q    <= '0;
      clr_row_q <= '0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        wait_q[p] <= '0;
      end
    end else begin
      if (cmd_i.clear) begin
        clr_row_q <= clr_row_q + 1'b1;
      end
      if (cmd_i.accept) begin
        if (start_q != '0) begin
          start_q <= start_q - 8'd1;
          done_q  <= '0;
        end else begin
          done_q <= done_d;
          for (int p = 0; p < NUM_PORTS; p++) begin
            wait_q[p] <= wait_d[p];
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ACCESS_LATENCY: lat_q   <= cfg_wdata_i[LAT_W-1:0];
          CFG_STARTUP_TICKS:  start_q <= cfg_wdata_i[START_W-1:0];
          CFG_SECOND_BASE:    base_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Hold the tick's request and clear read words at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      for (int p = 0; p < NUM_PORTS; p++) begin
        eaddr_q[p] <= eaddr[p];
        wdata_q[p] <= wdata_i[p];
        rdata_q[p] <= '0;
      end
    end else if (cmd_i.capture) begin
      rdata_q[cmd_i.port] <= rbytes;
    end
  end

  // Byte lane k holds bytes whose address is k modulo four; lanes below the
  // start offset take the next row.
  always_comb begin
    cur_addr = eaddr_q[cmd_i.port];
    cur_off  = cur_addr[1:0];
    row0     = cur_addr[AW-1:2];
    row1     = row0 + 1'b1;
    wbytes   = wdata_q[cmd_i.port];
    for (int k = 0; k < NUM_BANKS; k++) begin
      lane_sel[k] = 2'(k) - cur_off;
      byte_sel[k] = 2'(k) + cur_off;
      rbytes[k]   = bank_q[byte_sel[k]];
      if (cmd_i.clear) begin
        bank_addr[k]  = clr_row_q;
        bank_wdata[k] = '0;
      end else begin
        bank_addr[k]  = (2'(k) < cur_off) ? row1 : row0;
        bank_wdata[k] = wbytes[lane_sel[k]];
      end
    end
  end

  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    tpflr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.clear | cmd_i.mem_wr),
      .re_i    (cmd_i.mem_rd),
      .addr_i  (bank_addr[k]),
      .wdata_i (bank_wdata[k]),
      .rdata_o (bank_q[k])
    );
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_done_q <= done_q;
      for (int p = 0; p < NUM_PORTS; p++) begin
        out_rdata_q[p] <= rdata_q[p];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_done_o  = out_done_q;
  assign out_rdata_o = out_rdata_q;

  assign sts_o.clr_last = &clr_row_q;
  assign sts_o.done     = done_q;
  assign sts_o.func     = func_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ===== rtl/core/tpflr_checker.sv =====
// Port-level checker for the three-port RAM, bound to the top level.
`default_nettype none

module tpflr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        mem_done_o,
  input wire logic [31:0] mem_rdata_o,
  input wire logic        inst1_done_o,
  input wire logic [31:0] inst1_rdata_o,
  input wire logic        inst2_done_o,
  input wire logic [31:0] inst2_rdata_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One request at a time: after acceptance the block is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted while one is in flight");

  // A result only appears after the block has been working on a request.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work");

  // Ports that did not complete return a zero word.
  a_idle_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mem_done_o || mem_rdata_o == 32'd0) &&
                    (inst1_done_o || inst1_rdata_o == 32'd0) &&
                    (inst2_done_o || inst2_rdata_o == 32'd0))
    else $error("read word nonzero on a port that did not complete");

endmodule

bind three_port_fixed_latency_ram tpflr_checker u_tpflr_checker (.*);

`default_nettype wire
